### src/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared codes and controller/datapath interface types for the rational
// arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    // Default result range in bits
    localparam int DATA_WIDTH_DEF = 32;

    // Operation codes
    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_NEG  = 3'd4;
    localparam logic [2:0] OP_INC  = 3'd5;
    localparam logic [2:0] OP_CMP  = 3'd6;
    localparam logic [2:0] OP_NORM = 3'd7;

    // Status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_ZERO_DEN = 2'd1;
    localparam logic [1:0] STAT_OVF      = 2'd2;

    // Compare codes
    localparam logic [1:0] CMP_LT = 2'd0;
    localparam logic [1:0] CMP_EQ = 2'd1;
    localparam logic [1:0] CMP_GT = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic mul_en;
        logic comb_en;
        logic gcd_en;
        logic div_init;
        logic div_en;
        logic fin_en;
    } rau_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic err;
        logic is_cmp;
        logic num_zero;
        logic mul_last;
        logic gcd_done;
        logic div_done;
    } rau_stat_t;

endpackage

### src/rau_ctrl.sv
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer for the rational arithmetic unit: load, multiply, combine,
// GCD reduction, exact division, result formation and output handshake.
// ----------------------------------------------------------------------------
module rau_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output rau_pkg::rau_cmd_t  cmd,
    input  rau_pkg::rau_stat_t stat
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MUL  = 7'b0000010,
        ST_COMB = 7'b0000100,
        ST_GCD  = 7'b0001000,
        ST_DIV  = 7'b0010000,
        ST_FIN  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // Advance state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (stat.err) begin
                    state_next = ST_FIN;
                end else begin
                    cmd.mul_en = 1'b1;
                    if (stat.mul_last) begin
                        state_next = ST_COMB;
                    end
                end
            end
            ST_COMB: begin
                cmd.comb_en = 1'b1;
                state_next  = ST_GCD;
            end
            ST_GCD: begin
                if (stat.is_cmp || stat.num_zero) begin
                    state_next = ST_FIN;
                end else if (stat.gcd_done) begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end else begin
                    cmd.gcd_en = 1'b1;
                end
            end
            ST_DIV: begin
                cmd.div_en = 1'b1;
                if (stat.div_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                cmd.fin_en = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);

`ifndef SYNTH
    // Hold a result that is not taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped while stalled");

    // A result appears only after it was formed
    a_out_after_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_FIN))
        else $error("result shown without formation");

    // An error request skips the arithmetic
    a_err_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL && stat.err) |=> (state_reg == ST_FIN))
        else $error("error request not short-cut");

    // No request taken while busy
    a_no_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> !s_tready)
        else $error("request taken while busy");
`endif

endmodule

### src/rau_dpath.sv
// ----------------------------------------------------------------------------
// rau_dpath
// Datapath: operand capture, shared 32x32 multiplier, sign-magnitude combine
// and compare, binary GCD, dual restoring divider and result registers.
// ----------------------------------------------------------------------------
module rau_dpath #(
    parameter int DATA_WIDTH = rau_pkg::DATA_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic [2:0]         req_type,
    input  logic [31:0]        a_num,
    input  logic [31:0]        a_den,
    input  logic [31:0]        b_num,
    input  logic [31:0]        b_den,
    output logic [31:0]        res_num,
    output logic [30:0]        res_den,
    output logic [1:0]         cmp_result,
    output logic [1:0]         status,
    input  rau_pkg::rau_cmd_t  cmd,
    output rau_pkg::rau_stat_t stat
);

    localparam logic [63:0] LIM = 64'd1 << (DATA_WIDTH - 1);

    logic [2:0]  op_reg;
    logic [31:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic        sa_reg, sb_reg, err_reg;
    logic [1:0]  mul_cnt_reg;
    logic [63:0] p0_reg, p1_reg, p2_reg;
    logic        num_neg_reg;
    logic [63:0] num_mag_reg, den_reg;
    logic [1:0]  cmp_reg;
    logic [63:0] gx_reg, gy_reg;
    logic [5:0]  gk_reg;
    logic [63:0] g_reg, qn_reg, qd_reg;
    logic [64:0] rn_reg, rd_reg;
    logic [5:0]  div_cnt_reg;
    logic [31:0] res_num_reg;
    logic [30:0] res_den_reg;
    logic [1:0]  cmp_out_reg, status_reg;

    // Operand magnitudes and error check at capture
    logic [31:0] an_m, ad_m, bn_m, bd_m;
    logic        uses_b, err_in;
    assign an_m   = a_num[31] ? (32'd0 - a_num) : a_num;
    assign ad_m   = a_den[31] ? (32'd0 - a_den) : a_den;
    assign bn_m   = b_num[31] ? (32'd0 - b_num) : b_num;
    assign bd_m   = b_den[31] ? (32'd0 - b_den) : b_den;
    assign uses_b = (req_type <= rau_pkg::OP_DIV) || (req_type == rau_pkg::OP_CMP);
    assign err_in = (a_den == 32'd0) || (uses_b && b_den == 32'd0)
                  || (req_type == rau_pkg::OP_DIV && b_num == 32'd0);

    // Select multiplier operands per step
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (mul_cnt_reg)
            2'd0: begin
                mul_a = an_reg;
                case (op_reg)
                    rau_pkg::OP_MUL: mul_b = bn_reg;
                    rau_pkg::OP_ADD, rau_pkg::OP_SUB,
                    rau_pkg::OP_DIV, rau_pkg::OP_CMP: mul_b = bd_reg;
                    default: mul_b = 32'd1;
                endcase
            end
            2'd1: begin
                case (op_reg)
                    rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_CMP: begin
                        mul_a = bn_reg;
                        mul_b = ad_reg;
                    end
                    rau_pkg::OP_INC: begin
                        mul_a = ad_reg;
                        mul_b = 32'd1;
                    end
                    default: begin
                        mul_a = 32'd0;
                        mul_b = 32'd0;
                    end
                endcase
            end
            default: begin
                mul_a = ad_reg;
                case (op_reg)
                    rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_MUL: mul_b = bd_reg;
                    rau_pkg::OP_DIV: mul_b = bn_reg;
                    default: mul_b = 32'd1;
                endcase
            end
        endcase
    end
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // Signed combine and compare of the two product terms
    logic        sx, sy, xn, yn, cn;
    logic [63:0] cm;
    logic [1:0]  cc;
    always_comb begin
        case (op_reg)
            rau_pkg::OP_MUL, rau_pkg::OP_DIV: sx = sa_reg ^ sb_reg;
            rau_pkg::OP_NEG: sx = !sa_reg;
            default: sx = sa_reg;
        endcase
        case (op_reg)
            rau_pkg::OP_SUB: sy = !sb_reg;
            rau_pkg::OP_INC: sy = 1'b0;
            default: sy = sb_reg;
        endcase
        xn = sx && (p0_reg != 64'd0);
        yn = sy && (p1_reg != 64'd0);
        if (xn == yn) begin
            cm = p0_reg + p1_reg;
            cn = xn;
        end else if (p0_reg >= p1_reg) begin
            cm = p0_reg - p1_reg;
            cn = xn;
        end else begin
            cm = p1_reg - p0_reg;
            cn = yn;
        end
        if (xn != yn) begin
            cc = xn ? rau_pkg::CMP_LT : rau_pkg::CMP_GT;
        end else if (p0_reg == p1_reg) begin
            cc = rau_pkg::CMP_EQ;
        end else if (xn) begin
            cc = (p0_reg > p1_reg) ? rau_pkg::CMP_LT : rau_pkg::CMP_GT;
        end else begin
            cc = (p0_reg > p1_reg) ? rau_pkg::CMP_GT : rau_pkg::CMP_LT;
        end
    end

    // Divider step for both dividends
    logic [64:0] rn_sh, rd_sh, g_ext;
    logic        qn_bit, qd_bit;
    assign g_ext  = {1'b0, g_reg};
    assign rn_sh  = {rn_reg[63:0], qn_reg[63]};
    assign rd_sh  = {rd_reg[63:0], qd_reg[63]};
    assign qn_bit = (rn_sh >= g_ext);
    assign qd_bit = (rd_sh >= g_ext);

    // Result formation
    logic        f_zero, f_neg, f_ovf;
    logic [63:0] f_mag, f_den, f_num;
    assign f_zero = (num_mag_reg == 64'd0);
    assign f_mag  = f_zero ? 64'd0 : qn_reg;
    assign f_den  = f_zero ? 64'd1 : qd_reg;
    assign f_neg  = num_neg_reg && !f_zero;
    assign f_ovf  = (f_den > LIM - 64'd1) || (f_mag > (f_neg ? LIM : LIM - 64'd1));
    assign f_num  = f_neg ? (64'd0 - f_mag) : f_mag;

    always_ff @(posedge aclk) begin
        // Capture request
        if (cmd.load) begin
            op_reg      <= req_type;
            an_reg      <= an_m;
            ad_reg      <= ad_m;
            bn_reg      <= bn_m;
            bd_reg      <= bd_m;
            sa_reg      <= a_num[31] ^ a_den[31];
            sb_reg      <= b_num[31] ^ b_den[31];
            err_reg     <= err_in;
            mul_cnt_reg <= 2'd0;
        end
        // Multiply one term a cycle
        if (cmd.mul_en) begin
            case (mul_cnt_reg)
                2'd0:    p0_reg <= mul_p;
                2'd1:    p1_reg <= mul_p;
                default: p2_reg <= mul_p;
            endcase
            mul_cnt_reg <= mul_cnt_reg + 2'd1;
        end
        // Combine terms and seed GCD
        if (cmd.comb_en) begin
            num_neg_reg <= cn && (cm != 64'd0);
            num_mag_reg <= cm;
            den_reg     <= p2_reg;
            cmp_reg     <= cc;
            gx_reg      <= cm;
            gy_reg      <= p2_reg;
            gk_reg      <= 6'd0;
        end
        // Binary GCD step
        if (cmd.gcd_en) begin
            if (!gx_reg[0] && !gy_reg[0]) begin
                gx_reg <= gx_reg >> 1;
                gy_reg <= gy_reg >> 1;
                gk_reg <= gk_reg + 6'd1;
            end else if (!gx_reg[0]) begin
                gx_reg <= gx_reg >> 1;
            end else if (!gy_reg[0]) begin
                gy_reg <= gy_reg >> 1;
            end else if (gx_reg >= gy_reg) begin
                gx_reg <= gx_reg - gy_reg;
            end else begin
                gy_reg <= gy_reg - gx_reg;
            end
        end
        // Start division by the GCD
        if (cmd.div_init) begin
            g_reg       <= (gx_reg | gy_reg) << gk_reg;
            qn_reg      <= num_mag_reg;
            qd_reg      <= den_reg;
            rn_reg      <= 65'd0;
            rd_reg      <= 65'd0;
            div_cnt_reg <= 6'd0;
        end
        // One quotient bit a cycle
        if (cmd.div_en) begin
            rn_reg      <= qn_bit ? (rn_sh - g_ext) : rn_sh;
            rd_reg      <= qd_bit ? (rd_sh - g_ext) : rd_sh;
            qn_reg      <= {qn_reg[62:0], qn_bit};
            qd_reg      <= {qd_reg[62:0], qd_bit};
            div_cnt_reg <= div_cnt_reg + 6'd1;
        end
        // Form the result
        if (cmd.fin_en) begin
            res_num_reg <= 32'd0;
            res_den_reg <= 31'd0;
            cmp_out_reg <= rau_pkg::CMP_LT;
            status_reg  <= rau_pkg::STAT_OK;
            if (err_reg) begin
                status_reg <= rau_pkg::STAT_ZERO_DEN;
            end else if (op_reg == rau_pkg::OP_CMP) begin
                cmp_out_reg <= cmp_reg;
            end else if (f_ovf) begin
                status_reg <= rau_pkg::STAT_OVF;
            end else begin
                res_num_reg <= f_num[31:0];
                res_den_reg <= f_den[30:0];
            end
        end
    end

    assign stat.err      = err_reg;
    assign stat.is_cmp   = (op_reg == rau_pkg::OP_CMP);
    assign stat.num_zero = (num_mag_reg == 64'd0);
    assign stat.mul_last = (mul_cnt_reg == 2'd2);
    assign stat.gcd_done = (gx_reg == 64'd0) || (gy_reg == 64'd0);
    assign stat.div_done = (div_cnt_reg == 6'd63);

    assign res_num    = res_num_reg;
    assign res_den    = res_den_reg;
    assign cmp_result = cmp_out_reg;
    assign status     = status_reg;

endmodule

### src/rational_arith_unit.sv
// An error request skips the arithmetic; a compare or a zero result skips
// the GCD reduction and division. Otherwise the binary GCD loop and the
// 64-step restoring divider do most of the work.
// The next request is taken only after the result is delivered.
// Reset (aresetn low, synchronous) returns the sequencer to idle.
// ----------------------------------------------------------------------------
// rational_arith_unit
// Rational arithmetic on two fractions with GCD-reduced results.
// ----------------------------------------------------------------------------
module rational_arith_unit #(
    parameter int DATA_WIDTH = rau_pkg::DATA_WIDTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // req_type[2:0], a_num[34:3], a_den[66:35], b_num[98:67], b_den[130:99]
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // res_num[31:0], res_den[62:32], cmp_result[64:63], status[66:65]
    output logic [71:0]  m_tdata
);

    rau_pkg::rau_cmd_t  cmd;
    rau_pkg::rau_stat_t stat;
    logic [31:0] res_num;
    logic [30:0] res_den;
    logic [1:0]  cmp_result, status;

    rau_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    rau_dpath #(.DATA_WIDTH(DATA_WIDTH)) u_dpath (
        .aclk       (aclk),
        .req_type   (s_tdata[2:0]),
        .a_num      (s_tdata[34:3]),
        .a_den      (s_tdata[66:35]),
        .b_num      (s_tdata[98:67]),
        .b_den      (s_tdata[130:99]),
        .res_num    (res_num),
        .res_den    (res_den),
        .cmp_result (cmp_result),
        .status     (status),
        .cmd        (cmd),
        .stat       (stat)
    );

    assign m_tdata = {5'd0, status, cmp_result, res_den, res_num};

endmodule
